// ----- rtl/core/vlam_pkg.sv -----
// Shared types, widths and helper functions of the look-at view matrix block.
// Used by every module under rtl/core; depends on nothing else.

package vlam_pkg;

    localparam int unsigned DW = 32;    // Q16.16 field width
    localparam int unsigned VW = 51;    // width of a vector handed to the normalizer
    localparam int unsigned UW = 18;    // width of a unit vector component
    localparam int unsigned MW = 33;    // multiplier operand width
    localparam int unsigned PW = 2 * MW;

    localparam logic [DW-1:0] Q_ONE = 32'h0001_0000;

    typedef logic signed [DW-1:0] fix_t;
    typedef logic signed [DW:0]   diff_t;
    typedef logic signed [VW-1:0] wide_t;
    typedef logic signed [UW-1:0] unit_t;
    typedef logic signed [MW-1:0] mop_t;
    typedef logic signed [PW-1:0] prod_t;

    // One item as the back end needs it: eye, up and eye minus target.
    typedef struct packed {
        logic [2:0][DW-1:0] eye;
        logic [2:0][DW-1:0] up;
        logic [2:0][DW:0]   d;
    } job_t;

    // One matrix row as it leaves the block.
    typedef struct packed {
        logic [1:0]    row_index;
        logic [DW-1:0] elem0;
        logic [DW-1:0] elem1;
        logic [DW-1:0] elem2;
        logic [DW-1:0] elem3;
        logic          degenerate;
        logic          last_row;
    } row_t;

    // Status of the normalizer toward the sequencer.
    typedef struct packed {
        logic               done;
        logic               deg;
        logic [2:0][UW-1:0] v;
    } norm_res_t;

    function automatic mop_t ext_unit(input logic [UW-1:0] u);
        return {{(MW-UW){u[UW-1]}}, u};
    endfunction

    function automatic mop_t ext_fix(input logic [DW-1:0] f);
        return {{(MW-DW){f[DW-1]}}, f};
    endfunction

    // Operand order of a cross product a x b, one product per step:
    // a1*b2, a2*b1, a2*b0, a0*b2, a0*b1, a1*b0 (odd steps are subtracted).
    function automatic logic [1:0] cross_a_idx(input logic [2:0] k);
        logic [1:0] r;
        unique case (k)
            3'd0:    r = 2'd1;
            3'd1:    r = 2'd2;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd0;
            3'd5:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] cross_b_idx(input logic [2:0] k);
        logic [1:0] r;
        unique case (k)
            3'd0:    r = 2'd2;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd0;
            3'd3:    r = 2'd2;
            3'd4:    r = 2'd1;
            3'd5:    r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Translation products run row by row, three components per row.
    function automatic logic [1:0] tr_row(input logic [3:0] k);
        logic [1:0] r;
        if (k < 4'd3)
            r = 2'd0;
        else if (k < 4'd6)
            r = 2'd1;
        else
            r = 2'd2;
        return r;
    endfunction

    function automatic logic [1:0] tr_comp(input logic [3:0] k);
        logic [1:0] r;
        unique case (k)
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            4'd2, 4'd5, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    // Negate a Q19.32 dot product, round to Q16.16 with ties upward, saturate.
    function automatic logic [DW-1:0] round_sat(input wide_t acc);
        wide_t                t;
        logic [VW-17:0]       r;
        logic [DW-1:0]        o;
        t = -acc + wide_t'(32768);
        r = t[VW-1:16];
        if (r[VW-17:DW-1] == '0 || r[VW-17:DW-1] == '1)
            o = r[DW-1:0];
        else if (r[VW-17])
            o = 32'h8000_0000;
        else
            o = 32'h7FFF_FFFF;
        return o;
    endfunction

endpackage

// ----- rtl/core/vlam_front.sv -----
// Front end: accepts input items, unpacks them and forms eye minus target.
// Depends on vlam_pkg.

module vlam_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [287:0]        s_tdata,
    output logic                job_valid,
    input  logic                job_ready,
    output vlam_pkg::job_t      job
);

    logic           valid_reg;
    vlam_pkg::job_t job_reg;
    vlam_pkg::job_t job_in;
    logic           take;

    assign s_tready  = !valid_reg || job_ready;
    assign take      = s_tvalid && s_tready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            job_in.eye[i] = s_tdata[32*i +: 32];
            job_in.up[i]  = s_tdata[32*(6+i) +: 32];
            job_in.d[i]   = {s_tdata[32*i+31], s_tdata[32*i +: 32]}
                          - {s_tdata[32*(3+i)+31], s_tdata[32*(3+i) +: 32]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (job_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            job_reg <= job_in;
    end

endmodule

// ----- rtl/core/vlam_fifo.sv -----
// Short job queue between the front end and the back end.
// Depends on vlam_pkg for the job type.

module vlam_fifo
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           push_ready,
    input  vlam_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop,
    output vlam_pkg::job_t pop_job
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    vlam_pkg::job_t mem_reg [DEPTH];
    logic [AW-1:0]  wr_reg;
    logic [AW-1:0]  rd_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_job    = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_job;
    end

endmodule

// ----- rtl/core/vlam_norm.sv -----
// Vector normalizer: scales a 3-vector, takes a bit-serial square root of the
// sum of squares and divides each component bit by bit. Depends on vlam_pkg.

module vlam_norm
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  vlam_pkg::wide_t      vin [3],
    output vlam_pkg::norm_res_t  res
);

    localparam int unsigned VW = vlam_pkg::VW;

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_SQRT  = 3'd3;
    localparam logic [2:0] N_DIV   = 3'd4;

    logic [2:0]      st_reg, st_next;
    logic            done_reg, done_next;
    logic [VW-1:0]   m_reg [3];
    logic            neg_reg [3];
    vlam_pkg::unit_t q_reg [3];
    logic            deg_reg;
    logic [1:0]      k_reg;
    logic [4:0]      it_reg;
    logic [4:0]      d_reg;
    logic [59:0]     sq_reg;
    logic [61:0]     acc_reg;
    logic [61:0]     n_reg;
    logic [62:0]     rt_reg;
    logic [60:0]     bit_reg;
    logic [31:0]     len_reg;
    logic [32:0]     rem_reg;
    logic [16:0]     nb_reg;
    logic [16:0]     qb_reg;

    logic [VW-1:0]   mag_in [3];
    logic            in_zero;
    logic [VW-1:0]   mx;
    logic            in_range;
    logic [62:0]     rt_try;
    logic            rt_take;
    logic [62:0]     rt_new;
    logic [46:0]     num;
    logic [32:0]     r2;
    logic            d_take;
    logic [16:0]     qfin;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag_in[i] = vin[i][VW-1] ? VW'(-vin[i]) : VW'(vin[i]);
        in_zero = (mag_in[0] == '0) && (mag_in[1] == '0) && (mag_in[2] == '0);

        mx = m_reg[0];
        if (m_reg[1] > mx)
            mx = m_reg[1];
        if (m_reg[2] > mx)
            mx = m_reg[2];
        in_range = (mx[VW-1:30] == '0) && mx[29];

        rt_try  = rt_reg + {2'b00, bit_reg};
        rt_take = {1'b0, n_reg} >= rt_try;
        rt_new  = rt_take ? (rt_reg >> 1) + {2'b00, bit_reg} : rt_reg >> 1;

        num    = {1'b0, m_reg[k_reg][29:0], 16'h0000} + {16'h0000, len_reg[31:1]};
        r2     = {rem_reg[31:0], nb_reg[16]};
        d_take = r2 >= {1'b0, len_reg};
        qfin   = {qb_reg[15:0], d_take};
    end

    always_comb
    begin
        st_next   = st_reg;
        done_next = 1'b0;
        unique case (st_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    if (in_zero)
                        done_next = 1'b1;
                    else
                        st_next = N_SHIFT;
                end
            end
            N_SHIFT:
            begin
                if (in_range)
                    st_next = N_SQ;
            end
            N_SQ:
            begin
                if (k_reg == 2'd3)
                    st_next = N_SQRT;
            end
            N_SQRT:
            begin
                if (it_reg == 5'd30)
                    st_next = N_DIV;
            end
            N_DIV:
            begin
                if (k_reg == 2'd2 && d_reg == 5'd17)
                begin
                    st_next   = N_IDLE;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                st_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= N_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i]   <= mag_in[i];
                        neg_reg[i] <= vin[i][VW-1];
                        q_reg[i]   <= '0;
                    end
                    deg_reg <= in_zero;
                    k_reg   <= 2'd0;
                    acc_reg <= '0;
                end
            end
            N_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (mx[VW-1:34] != '0)
                        m_reg[i] <= m_reg[i] >> 4;
                    else if (mx[VW-1:30] != '0)
                        m_reg[i] <= m_reg[i] >> 1;
                    else if (mx[VW-1:25] == '0)
                        m_reg[i] <= m_reg[i] << 4;
                    else if (!mx[29])
                        m_reg[i] <= m_reg[i] << 1;
                end
            end
            N_SQ:
            begin
                if (k_reg != 2'd3)
                    sq_reg <= m_reg[k_reg][29:0] * m_reg[k_reg][29:0];
                if (k_reg != 2'd0)
                    acc_reg <= acc_reg + {2'b00, sq_reg};
                if (k_reg == 2'd3)
                begin
                    n_reg   <= acc_reg + {2'b00, sq_reg};
                    rt_reg  <= '0;
                    bit_reg <= {1'b1, 60'h0};
                    it_reg  <= '0;
                    k_reg   <= 2'd0;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            N_SQRT:
            begin
                if (rt_take)
                    n_reg <= n_reg - rt_try[61:0];
                rt_reg  <= rt_new;
                bit_reg <= bit_reg >> 2;
                it_reg  <= it_reg + 1'b1;
                len_reg <= rt_new[31:0];
                d_reg   <= '0;
            end
            N_DIV:
            begin
                if (d_reg == 5'd0)
                begin
                    rem_reg <= {3'b000, num[46:17]};
                    nb_reg  <= num[16:0];
                    qb_reg  <= '0;
                    d_reg   <= 5'd1;
                end
                else
                begin
                    rem_reg <= d_take ? r2 - {1'b0, len_reg} : r2;
                    nb_reg  <= nb_reg << 1;
                    qb_reg  <= qfin;
                    if (d_reg == 5'd17)
                    begin
                        q_reg[k_reg] <= neg_reg[k_reg] ? -$signed({1'b0, qfin})
                                                       : $signed({1'b0, qfin});
                        k_reg <= k_reg + 1'b1;
                        d_reg <= '0;
                    end
                    else
                    begin
                        d_reg <= d_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.done = done_reg;
    assign res.deg  = deg_reg;
    assign res.v[0] = q_reg[0];
    assign res.v[1] = q_reg[1];
    assign res.v[2] = q_reg[2];

endmodule

// ----- rtl/core/vlam_back.sv -----
// Back end: sequences the three normalizations, cross products and
// translation terms of one job and emits its four rows. Depends on vlam_pkg
// and vlam_norm.

module vlam_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  vlam_pkg::job_t job,
    output logic           m_tvalid,
    input  logic           m_tready,
    output vlam_pkg::row_t m_row
);

    localparam int unsigned VW = vlam_pkg::VW;

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_NZ   = 4'd1;
    localparam logic [3:0] B_CX   = 4'd2;
    localparam logic [3:0] B_SX   = 4'd3;
    localparam logic [3:0] B_NX   = 4'd4;
    localparam logic [3:0] B_CY   = 4'd5;
    localparam logic [3:0] B_SY   = 4'd6;
    localparam logic [3:0] B_NY   = 4'd7;
    localparam logic [3:0] B_TR   = 4'd8;
    localparam logic [3:0] B_OUT  = 4'd9;

    logic [3:0]          st_reg, st_next;
    logic [3:0]          cnt_reg;
    logic [1:0]          rcnt_reg;
    logic                deg_reg;
    logic [2:0][31:0]    eye_reg;
    logic [2:0][31:0]    up_reg;
    vlam_pkg::unit_t     z_reg [3];
    vlam_pkg::unit_t     x_reg [3];
    vlam_pkg::unit_t     y_reg [3];
    vlam_pkg::wide_t     c_reg [3];
    vlam_pkg::wide_t     t_reg [3];
    vlam_pkg::prod_t     p_reg;
    logic                out_valid_reg;
    vlam_pkg::row_t      out_reg;

    logic                nstart;
    vlam_pkg::wide_t     nvin [3];
    vlam_pkg::norm_res_t nres;
    vlam_pkg::mop_t      mul_a;
    vlam_pkg::mop_t      mul_b;
    logic [3:0]          kk;
    logic [1:0]          ai, bi, trr, trc;
    logic                load_out;
    vlam_pkg::row_t      row_next;
    vlam_pkg::wide_t     p_w;

    assign job_ready = st_reg == B_IDLE;
    assign nstart    = (st_reg == B_IDLE && job_valid) || st_reg == B_SX || st_reg == B_SY;
    assign load_out  = st_reg == B_OUT && (!out_valid_reg || m_tready);
    assign kk        = cnt_reg - 1'b1;
    assign p_w       = p_reg[VW-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            nvin[i] = (st_reg == B_IDLE) ? VW'($signed(job.d[i])) : c_reg[i];
    end

    vlam_norm u_norm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (nstart),
        .vin   (nvin),
        .res   (nres)
    );

    // Shared multiplier operands.
    always_comb
    begin
        ai  = vlam_pkg::cross_a_idx(cnt_reg[2:0]);
        bi  = vlam_pkg::cross_b_idx(cnt_reg[2:0]);
        trr = vlam_pkg::tr_row(cnt_reg);
        trc = vlam_pkg::tr_comp(cnt_reg);
        if (st_reg == B_CX)
        begin
            mul_a = vlam_pkg::ext_fix(up_reg[ai]);
            mul_b = vlam_pkg::ext_unit(z_reg[bi]);
        end
        else if (st_reg == B_CY)
        begin
            mul_a = vlam_pkg::ext_unit(z_reg[ai]);
            mul_b = vlam_pkg::ext_unit(x_reg[bi]);
        end
        else
        begin
            priority case (trr)
                2'd0:    mul_a = vlam_pkg::ext_unit(x_reg[trc]);
                2'd1:    mul_a = vlam_pkg::ext_unit(y_reg[trc]);
                default: mul_a = vlam_pkg::ext_unit(z_reg[trc]);
            endcase
            mul_b = vlam_pkg::ext_fix(eye_reg[trc]);
        end
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            B_IDLE: if (job_valid) st_next = B_NZ;
            B_NZ:   if (nres.done) st_next = B_CX;
            B_CX:   if (cnt_reg == 4'd6) st_next = B_SX;
            B_SX:   st_next = B_NX;
            B_NX:   if (nres.done) st_next = B_CY;
            B_CY:   if (cnt_reg == 4'd6) st_next = B_SY;
            B_SY:   st_next = B_NY;
            B_NY:   if (nres.done) st_next = B_TR;
            B_TR:   if (cnt_reg == 4'd9) st_next = B_OUT;
            B_OUT:  if (load_out && rcnt_reg == 2'd3) st_next = B_IDLE;
            default: st_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        row_next.row_index  = rcnt_reg;
        row_next.degenerate = deg_reg;
        row_next.last_row   = rcnt_reg == 2'd3;
        unique case (rcnt_reg)
            2'd0:
            begin
                row_next.elem0 = 32'($signed(x_reg[0]));
                row_next.elem1 = 32'($signed(x_reg[1]));
                row_next.elem2 = 32'($signed(x_reg[2]));
                row_next.elem3 = vlam_pkg::round_sat(t_reg[0]);
            end
            2'd1:
            begin
                row_next.elem0 = 32'($signed(y_reg[0]));
                row_next.elem1 = 32'($signed(y_reg[1]));
                row_next.elem2 = 32'($signed(y_reg[2]));
                row_next.elem3 = vlam_pkg::round_sat(t_reg[1]);
            end
            2'd2:
            begin
                row_next.elem0 = 32'($signed(z_reg[0]));
                row_next.elem1 = 32'($signed(z_reg[1]));
                row_next.elem2 = 32'($signed(z_reg[2]));
                row_next.elem3 = vlam_pkg::round_sat(t_reg[2]);
            end
            default:
            begin
                row_next.elem0 = '0;
                row_next.elem1 = '0;
                row_next.elem2 = '0;
                row_next.elem3 = vlam_pkg::Q_ONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= mul_a * mul_b;
        if (load_out)
            out_reg <= row_next;
        unique case (st_reg)
            B_IDLE:
            begin
                eye_reg  <= job.eye;
                up_reg   <= job.up;
                deg_reg  <= 1'b0;
                cnt_reg  <= '0;
                rcnt_reg <= '0;
            end
            B_NZ, B_NX, B_NY:
            begin
                if (nres.done)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (st_reg == B_NZ)
                            z_reg[i] <= nres.v[i];
                        else if (st_reg == B_NX)
                            x_reg[i] <= nres.v[i];
                        else
                            y_reg[i] <= nres.v[i];
                    end
                    deg_reg <= deg_reg | nres.deg;
                end
                cnt_reg <= '0;
            end
            B_CX, B_CY:
            begin
                if (cnt_reg != 4'd0)
                    c_reg[kk[2:1]] <= kk[0] ? c_reg[kk[2:1]] - p_w : p_w;
                cnt_reg <= cnt_reg + 1'b1;
            end
            B_TR:
            begin
                if (cnt_reg != 4'd0)
                    t_reg[vlam_pkg::tr_row(kk)] <= (vlam_pkg::tr_comp(kk) == 2'd0)
                        ? p_w : t_reg[vlam_pkg::tr_row(kk)] + p_w;
                cnt_reg <= cnt_reg + 1'b1;
            end
            B_OUT:
            begin
                if (load_out)
                    rcnt_reg <= rcnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_row    = out_reg;

endmodule

// ----- rtl/core/view_matrix_look_at.sv -----
// Top level of the look-at view matrix generator: front end, job queue and
// back end. Depends on vlam_pkg, vlam_front, vlam_fifo and vlam_back.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata: eye, target, up (Q16.16)
//   m_       out  m_tvalid/m_tready  m_tdata: row elements, m_tuser, m_tlast
//
// Each item produces four rows, row 0 to row 3. In the back end an item takes
// three normalizations, each done by the one-bit-per-cycle square root and
// divider in vlam_norm, plus the cross products and translation terms on one
// shared 33x33 multiplier and the row output. A zero-length vector ends its
// normalization without the scaling, square root and divide steps, so
// degenerate items finish sooner.
// Reset is asynchronous and active low; it empties the queue and the output
// register. The front end keeps accepting items into the queue while the back
// end works or the output is stalled; s_tready drops only when the queue and
// the front register are full.

module view_matrix_look_at
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // elem0, elem1, elem2, elem3
    output logic [127:0] m_tdata,
    // row_index (2 bits), degenerate
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    logic           f_valid;
    logic           f_ready;
    vlam_pkg::job_t f_job;
    logic           q_valid;
    logic           q_pop;
    vlam_pkg::job_t q_job;
    vlam_pkg::row_t row;

    // Front end: one register stage that also forms eye minus target.
    vlam_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    // Queue of jobs waiting for the back end.
    vlam_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_job    (q_job)
    );

    // Back end: sequencer, normalizer and output register.
    vlam_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_pop),
        .job       (q_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_row     (row)
    );

    assign m_tdata = {row.elem3, row.elem2, row.elem1, row.elem0};
    assign m_tuser = {row.degenerate, row.row_index};
    assign m_tlast = row.last_row;

endmodule
